// ----- hdl/utf8v_pkg.sv -----
// utf8v_pkg: shared types and constants for the utf-8 stream validator
// no dependencies; used by utf8v_step, utf8_stream_validator_core and utf8_verdict_checker
`timescale 1ns / 1ps

package utf8v_pkg;

   localparam int unsigned CodeWidth = 21;

   // byte classification masks and patterns
   localparam logic [7:0] AsciiLimit    = 8'h80;
   localparam logic [7:0] Lead2Mask     = 8'he0;
   localparam logic [7:0] Lead2Pattern  = 8'hc0;
   localparam logic [7:0] Lead3Mask     = 8'hf0;
   localparam logic [7:0] Lead3Pattern  = 8'he0;
   localparam logic [7:0] Lead4Mask     = 8'hf8;
   localparam logic [7:0] Lead4Pattern  = 8'hf0;
   localparam logic [7:0] ContMask      = 8'hc0;
   localparam logic [7:0] ContPattern   = 8'h80;
   localparam logic [7:0] ContPayload   = 8'h3f;

   // code point limits
   localparam logic [CodeWidth-1:0] Min2Byte     = 21'h000080;
   localparam logic [CodeWidth-1:0] Min3Byte     = 21'h000800;
   localparam logic [CodeWidth-1:0] Min4Byte     = 21'h010000;
   localparam logic [CodeWidth-1:0] MaxCode      = 21'h10ffff;
   localparam logic [CodeWidth-1:0] SurrogateLow = 21'h00d800;
   localparam logic [CodeWidth-1:0] SurrogateHigh = 21'h00dfff;

   // sequence lengths, counted in continuation bytes
   localparam logic [1:0] SeqNone  = 2'd0;
   localparam logic [1:0] SeqTwo   = 2'd1;
   localparam logic [1:0] SeqThree = 2'd2;
   localparam logic [1:0] SeqFour  = 2'd3;

   typedef struct packed {
      logic [1:0]           pending_count;
      logic [1:0]           sequence_length;
      logic [CodeWidth-1:0] code_accum;
      logic                 error_seen;
   } decode_state_type;

endpackage

// ----- hdl/utf8v_step.sv -----
// utf8v_step: next-state and verdict logic for one byte of the stream
// depends on utf8v_pkg
`timescale 1ns / 1ps

module utf8v_step (
   input  utf8v_pkg::decode_state_type state_cur,
   input  logic [7:0]                  data_byte,
   input  logic                        has_byte,
   input  logic                        last,
   output utf8v_pkg::decode_state_type state_next,
   output logic                        ok
);

   utf8v_pkg::decode_state_type       upd;
   logic [utf8v_pkg::CodeWidth-1:0]   cp;
   logic [1:0]                        pend_dec;
   logic                              bad_cp;

   assign cp       = {state_cur.code_accum[utf8v_pkg::CodeWidth-7:0],
                      data_byte[5:0] & utf8v_pkg::ContPayload[5:0]};
   assign pend_dec = state_cur.pending_count - 2'd1;

   always_comb begin
      bad_cp = ((state_cur.sequence_length == utf8v_pkg::SeqTwo)   && (cp < utf8v_pkg::Min2Byte))
            || ((state_cur.sequence_length == utf8v_pkg::SeqThree) && (cp < utf8v_pkg::Min3Byte))
            || ((state_cur.sequence_length == utf8v_pkg::SeqFour)  && (cp < utf8v_pkg::Min4Byte))
            || (cp > utf8v_pkg::MaxCode)
            || ((cp >= utf8v_pkg::SurrogateLow) && (cp <= utf8v_pkg::SurrogateHigh));
   end

   always_comb begin
      upd = state_cur;
      if (has_byte && !state_cur.error_seen) begin
         if (state_cur.pending_count == 2'd0) begin
            // lead byte
            if (data_byte < utf8v_pkg::AsciiLimit) begin
               if (data_byte == 8'd0) begin
                  upd.error_seen = 1'b1;
               end
            end else if ((data_byte & utf8v_pkg::Lead2Mask) == utf8v_pkg::Lead2Pattern) begin
               upd.sequence_length = utf8v_pkg::SeqTwo;
               upd.pending_count   = utf8v_pkg::SeqTwo;
               upd.code_accum      = {16'd0, data_byte[4:0]};
            end else if ((data_byte & utf8v_pkg::Lead3Mask) == utf8v_pkg::Lead3Pattern) begin
               upd.sequence_length = utf8v_pkg::SeqThree;
               upd.pending_count   = utf8v_pkg::SeqThree;
               upd.code_accum      = {17'd0, data_byte[3:0]};
            end else if ((data_byte & utf8v_pkg::Lead4Mask) == utf8v_pkg::Lead4Pattern) begin
               upd.sequence_length = utf8v_pkg::SeqFour;
               upd.pending_count   = utf8v_pkg::SeqFour;
               upd.code_accum      = {18'd0, data_byte[2:0]};
            end else begin
               upd.error_seen = 1'b1;
            end
         end else begin
            // continuation byte
            if ((data_byte & utf8v_pkg::ContMask) != utf8v_pkg::ContPattern) begin
               upd.error_seen = 1'b1;
            end else begin
               upd.code_accum    = cp;
               upd.pending_count = pend_dec;
               if ((pend_dec == 2'd0) && bad_cp) begin
                  upd.error_seen = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      ok         = !upd.error_seen && (upd.pending_count == 2'd0);
      state_next = last ? '0 : upd;
   end

endmodule

// ----- hdl/utf8_stream_validator_core.sv -----
// utf8_stream_validator_core: strict utf-8 checker, at most one byte per transaction
// depends on utf8v_pkg and utf8v_step
//
//   channel | dir | tdata             | tuser        | tlast
//   req     | in  | [7:0] data_byte   | [0] has_byte | last
//   rsp     | out | [0] ok, [7:1] zero| -            | -
//
// one byte is accepted every cycle unless a held last transaction stalls the input;
// the verdict of the transaction marked last passes the input register, then the result register
// reset clears the decode state and both registers; a partial message is dropped
// only a held verdict in the result register stalls the input, and only for a
// transaction that carries last; bytes that produce no verdict keep flowing
`timescale 1ns / 1ps

module utf8_stream_validator_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] has_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] ok, [7:1] zero
);

   logic                        in_valid_ff, in_valid_in;
   logic [7:0]                  in_data_ff, in_data_in;
   logic                        in_has_ff, in_has_in;
   logic                        in_last_ff, in_last_in;
   utf8v_pkg::decode_state_type state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff, rsp_ok_in;

   utf8v_pkg::decode_state_type step_state;
   logic                        step_ok;
   logic                        step_fire;
   logic                        req_fire;

   utf8v_step u_step (
      .state_cur  (state_ff),
      .data_byte  (in_data_ff),
      .has_byte   (in_has_ff),
      .last       (in_last_ff),
      .state_next (step_state),
      .ok         (step_ok)
   );

   // a held item moves on unless it needs the result slot and that is full
   assign step_fire  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_has_in   = in_has_ff;
      in_last_in  = in_last_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_data_in  = req_tdata;
         in_has_in   = req_tuser;
         in_last_in  = req_tlast;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = step_fire ? step_state : state_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (step_fire && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = step_ok;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      in_has_ff  <= in_has_in;
      in_last_ff <= in_last_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ok_ff};

   // continuation count never exceeds the length of the open sequence
   assert property (@(posedge clock) disable iff (reset)
      state_ff.pending_count <= state_ff.sequence_length)
      else $error("pending count above sequence length");

   // end of message always leaves a clean decode state
   assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_last_ff) |=> (state_ff == '0))
      else $error("state not cleared after verdict");

   // the input only stalls behind a held item
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_last_ff && rsp_valid_ff))
      else $error("input stalled without a blocked verdict");

   // a verdict is loaded exactly when a last item leaves the input register
   assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_last_ff) |=> rsp_valid_ff)
      else $error("verdict lost");

endmodule

// ----- test/utf8_verdict_checker.sv -----
// utf8_verdict_checker: watches both channels of the utf-8 validator, predicts each verdict
// and compares it with the block's output; depends on utf8v_pkg for the state type and limits
`timescale 1ns / 1ps

module utf8_verdict_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tuser,    // [0] has_byte
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,    // [0] ok, [7:1] zero
   output int         fail_count,
   output int         verdicts_owed
);

   utf8v_pkg::decode_state_type decoder = '0;
   logic                        expected_verdicts[$];
   int                          errors = 0;

   // one byte through the decoder, only called while no fault is recorded
   function automatic utf8v_pkg::decode_state_type decode_byte(
         input utf8v_pkg::decode_state_type s, input logic [7:0] b);
      utf8v_pkg::decode_state_type n;
      logic [utf8v_pkg::CodeWidth-1:0] cp;
      n = s;
      if (s.pending_count == utf8v_pkg::SeqNone) begin
         n.code_accum = '0;
         if (b < utf8v_pkg::AsciiLimit) begin
            if (b == 8'h00) n.error_seen = 1'b1;
            n.code_accum = s.code_accum;
         end else if ((b & utf8v_pkg::Lead2Mask) == utf8v_pkg::Lead2Pattern) begin
            n.sequence_length = utf8v_pkg::SeqTwo;
            n.code_accum[4:0] = b[4:0];
         end else if ((b & utf8v_pkg::Lead3Mask) == utf8v_pkg::Lead3Pattern) begin
            n.sequence_length = utf8v_pkg::SeqThree;
            n.code_accum[3:0] = b[3:0];
         end else if ((b & utf8v_pkg::Lead4Mask) == utf8v_pkg::Lead4Pattern) begin
            n.sequence_length = utf8v_pkg::SeqFour;
            n.code_accum[2:0] = b[2:0];
         end else begin
            n.error_seen = 1'b1;
            n.code_accum = s.code_accum;
         end
         if (b >= utf8v_pkg::AsciiLimit && !n.error_seen) n.pending_count = n.sequence_length;
      end else if ((b & utf8v_pkg::ContMask) != utf8v_pkg::ContPattern) begin
         n.error_seen = 1'b1;
      end else begin
         cp = {s.code_accum[utf8v_pkg::CodeWidth-7:0], b[5:0]};
         n.code_accum = cp;
         n.pending_count = s.pending_count - 2'd1;
         // sequence complete: overlong, out of range and surrogate checks
         if (n.pending_count == utf8v_pkg::SeqNone &&
             ((s.sequence_length == utf8v_pkg::SeqTwo && cp < utf8v_pkg::Min2Byte) ||
              (s.sequence_length == utf8v_pkg::SeqThree && cp < utf8v_pkg::Min3Byte) ||
              (s.sequence_length == utf8v_pkg::SeqFour && cp < utf8v_pkg::Min4Byte) ||
              cp > utf8v_pkg::MaxCode ||
              (cp >= utf8v_pkg::SurrogateLow && cp <= utf8v_pkg::SurrogateHigh)))
            n.error_seen = 1'b1;
      end
      return n;
   endfunction

   always @(posedge clock) begin : watch
      logic ok_expected;
      if (reset) begin
         decoder = '0;
         expected_verdicts.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser && !decoder.error_seen) decoder = decode_byte(decoder, req_tdata);
            if (req_tlast) begin
               expected_verdicts.push_back(!decoder.error_seen &&
                                           decoder.pending_count == utf8v_pkg::SeqNone);
               decoder = '0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               $error("verdict with none pending: rsp_tdata=%h", rsp_tdata);
               errors++;
            end else begin
               ok_expected = expected_verdicts.pop_front();
               if (rsp_tdata[0] !== ok_expected) begin
                  $error("ok mismatch: expected %0b, actual %0b", ok_expected, rsp_tdata[0]);
                  errors++;
               end
               if (rsp_tdata[7:1] !== 7'd0) begin
                  $error("pad mismatch: expected 0, actual %h", rsp_tdata[7:1]);
                  errors++;
               end
            end
         end
      end
      fail_count    <= errors;
      verdicts_owed <= expected_verdicts.size();
   end

endmodule

// ----- test/tb_utf8_stream_validator_core.sv -----
// tb_utf8_stream_validator_core: drives byte messages into the utf-8 validator with random
// gaps and stalls; depends on utf8_stream_validator_core and utf8_verdict_checker
`timescale 1ns / 1ps

module tb_utf8_stream_validator_core;

   localparam int CycleLimit  = 300000;
   localparam int RandomItems = 1500;

   // {has_byte, last} of a directed transaction
   localparam logic [1:0] MarkIdle     = 2'b00;
   localparam logic [1:0] MarkEnd      = 2'b01;
   localparam logic [1:0] MarkByte     = 2'b10;
   localparam logic [1:0] MarkByteLast = 2'b11;

   localparam int DirectedCount = 26;
   localparam logic [9:0] Directed[DirectedCount] = '{
      {MarkByteLast, 8'h00},                                    // zero byte
      {MarkEnd, 8'h00},                                         // empty message
      {MarkIdle, 8'hA5}, {MarkByteLast, 8'h7F},                 // ignored, then ascii
      {MarkByte, 8'hC2}, {MarkByteLast, 8'h80},                 // smallest two-byte
      {MarkByte, 8'hC1}, {MarkByteLast, 8'hBF},                 // overlong
      {MarkByte, 8'hED}, {MarkByte, 8'hA0}, {MarkByteLast, 8'h80}, // surrogate
      {MarkByte, 8'hF4}, {MarkByte, 8'h90}, {MarkByte, 8'h80},
      {MarkByteLast, 8'h80},                                    // above 10ffff
      {MarkByte, 8'hF0}, {MarkByte, 8'h90}, {MarkByte, 8'h80},
      {MarkByteLast, 8'h80},                                    // smallest four-byte
      {MarkByte, 8'hFF}, {MarkByteLast, 8'h41},                 // bad lead, byte after fault
      {MarkByte, 8'hE2}, {MarkByteLast, 8'h41},                 // bad continuation
      {MarkByte, 8'hE2}, {MarkByte, 8'h82}, {MarkEnd, 8'h00}    // cut short at the end
   };

   typedef enum int {
      FaultNone, FaultZero, FaultScramble, FaultOverlong,
      FaultSurrogate, FaultTooHigh, FaultCutShort, FaultStray
   } fault_kind_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] data_byte
   logic       req_tuser;    // [0] has_byte
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [0] ok, [7:1] zero
   int         fail_count;
   int         verdicts_owed;

   logic [7:0] msg_bytes[$];
   logic       sender_idles = 1'b1;
   logic       receiver_stalls = 1'b1;
   int         items_sent = 0;

   utf8_stream_validator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   utf8_verdict_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .verdicts_owed (verdicts_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
   end

   // result side: random stall before each verdict, with stretches of none
   initial begin : receiver
      int gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 7) == 0) receiver_stalls = !receiver_stalls;
         gap = receiver_stalls ? $urandom_range(0, 11) : 0;
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_item(input logic [7:0] b, input logic has, input logic last);
      int gap;
      gap = sender_idles ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= has;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (has || last) items_sent++;
   endtask

   task automatic drain_verdicts();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (verdicts_owed != 0);
   endtask

   function automatic void append_code(input logic [20:0] cp, input int n);
      case (n)
         1: msg_bytes.push_back({1'b0, cp[6:0]});
         2: begin
            msg_bytes.push_back({3'b110, cp[10:6]});
            msg_bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            msg_bytes.push_back({4'b1110, cp[15:12]});
            msg_bytes.push_back({2'b10, cp[11:6]});
            msg_bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            msg_bytes.push_back({5'b11110, cp[20:18]});
            msg_bytes.push_back({2'b10, cp[17:12]});
            msg_bytes.push_back({2'b10, cp[11:6]});
            msg_bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   function automatic logic [20:0] legal_code(input int n);
      logic [20:0] cp;
      case (n)
         1: cp = 21'($urandom_range(1, 'h7F));
         2: cp = 21'($urandom_range('h80, 'h7FF));
         3: begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 21'h2000;
         end
         default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
      return cp;
   endfunction

   // mostly well-formed text with at most one fault spliced in
   function automatic void build_message();
      int             n_chars;
      int             fault_at;
      int             len;
      fault_kind_type fault;
      msg_bytes.delete();
      n_chars  = $urandom_range(0, 6);
      fault    = ($urandom_range(0, 3) == 0) ? fault_kind_type'($urandom_range(1, 7)) : FaultNone;
      fault_at = $urandom_range(0, n_chars);
      for (int i = 0; i <= n_chars; i++) begin
         if (i == fault_at) begin
            case (fault)
               FaultZero: msg_bytes.push_back(8'h00);
               FaultOverlong: begin
                  len = $urandom_range(2, 4);
                  append_code(21'(len == 2 ? $urandom_range(0, 'h7F) :
                                  len == 3 ? $urandom_range(0, 'h7FF) :
                                             $urandom_range(0, 'hFFFF)),
                              len);
               end
               FaultSurrogate: append_code(21'($urandom_range('hD800, 'hDFFF)), 3);
               FaultTooHigh:   append_code(21'($urandom_range('h110000, 'h1FFFFF)), 4);
               FaultCutShort: begin
                  len = $urandom_range(2, 4);
                  append_code(legal_code(len), len);
                  repeat ($urandom_range(1, len - 1)) void'(msg_bytes.pop_back());
               end
               FaultStray: msg_bytes.push_back(8'($urandom_range(0, 1) ?
                                                  $urandom_range('h80, 'hBF) :
                                                  $urandom_range('hF8, 'hFF)));
               default: ;
            endcase
         end
         if (i < n_chars) begin
            len = $urandom_range(1, 4);
            append_code(legal_code(len), len);
         end
      end
      if (fault == FaultScramble && msg_bytes.size() != 0)
         msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
   endfunction

   initial begin : stimulus
      logic end_on_byte;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (Directed[i])
         send_item(Directed[i][7:0], Directed[i][9], Directed[i][8]);
      drain_verdicts();

      items_sent = 0;
      while (items_sent < RandomItems) begin
         build_message();
         if ($urandom_range(0, 5) == 0) sender_idles = !sender_idles;
         end_on_byte = (msg_bytes.size() != 0) && ($urandom_range(0, 1) == 1);
         foreach (msg_bytes[i]) begin
            if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(msg_bytes[i], 1'b1, end_on_byte && i == msg_bytes.size() - 1);
         end
         if (!end_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         if ($urandom_range(0, 39) == 0) drain_verdicts();
      end

      drain_verdicts();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && verdicts_owed == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
